// ===== hdl/bdq_pkg.sv =====
`default_nettype none

package bdq_pkg;

  // Default number of entries held by the deque.
  localparam int DEPTH_DEF = 64;

  // Width of the count field carried in a result item.
  localparam int COUNT_W = 7;

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_CONTAINS   = 3'd4,
    CMD_REMOVE     = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_SHIFT,
    S_FETCH,
    S_FRONT,
    S_BACK
  } state_e;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] value;
  } cmd_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               found;
    logic [COUNT_W-1:0] count;
    logic signed [31:0] front_value;
    logic signed [31:0] back_value;
  } result_item_t;

endpackage

`default_nettype wire

// ===== hdl/bounded_deque_bag.sv =====
// The result is formed once the command has run and the front and back entries are read, or
// as soon as the command has run when the deque is empty after it. Contains and remove first
// scan the held entries; a remove that matches then moves each entry behind the match down.
// The block takes one item at a time; busy drops in the cycle the result is shown, so the next
// item can be accepted at the edge that takes the result. Reset (rst, synchronous) empties the
// deque and clears the strobe; stored entries are not cleared. The receiver cannot stall.
`default_nettype none

module bounded_deque_bag
  import bdq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  output logic              busy,
  input  wire cmd_item_t    command,
  output logic              done,
  output result_item_t      result
);

  localparam int AW = $clog2(DEPTH);

  // Memory port between the sequencer and the entry store. The store reads
  // every cycle, so read data is registered and follows the read address in the next cycle.
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [31:0]   mem_rdata;

  // Result as the sequencer forms it, in the cycle before it is presented.
  logic          res_valid;
  result_item_t  res;

  // The sequencer handles one item at a time. A push or pop updates the
  // head pointer and count in one step; contains and remove scan the held
  // entries front to back, one read per cycle through the shared slot unit,
  // and remove then moves each later entry down by one slot to close the
  // gap. Every command that leaves the deque non-empty ends by reading the front and back entries.
  bdq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .command   (command),
    .busy      (busy),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .res_valid (res_valid),
    .res       (res)
  );

  bdq_store #(.DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Output register. The strobe is high for exactly one cycle per item, and
  // the sequencer is already idle in that cycle, so the next item can be
  // accepted while the result is on the ports.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      result <= res;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/bdq_slot.sv =====
`default_nettype none

// Circular slot arithmetic: (head + offset) modulo DEPTH with one add and
// one compare-subtract, since both operands stay below DEPTH.
module bdq_slot
  import bdq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic [$clog2(DEPTH)-1:0] head,
  input  wire logic [$clog2(DEPTH)-1:0] offset,
  output logic      [$clog2(DEPTH)-1:0] slot
);

  localparam int AW = $clog2(DEPTH);

  logic [AW:0] sum;

  always_comb begin
    sum = {1'b0, head} + {1'b0, offset};
    if (sum >= (AW+1)'(DEPTH)) begin
      sum = sum - (AW+1)'(DEPTH);
    end
    slot = sum[AW-1:0];
  end

endmodule

`default_nettype wire

// ===== hdl/bdq_store.sv =====
`default_nettype none

// Entry storage: one write port, one read port with registered read data.
module bdq_store
  import bdq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [31:0]              wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [31:0]              rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hdl/bdq_ctrl.sv =====
`default_nettype none

// Command sequencer. All slot addresses come from one shared bdq_slot unit.
module bdq_ctrl
  import bdq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire cmd_item_t                command,
  output logic                          busy,
  output logic                          mem_we,
  output logic      [$clog2(DEPTH)-1:0] mem_waddr,
  output logic      [31:0]              mem_wdata,
  output logic      [$clog2(DEPTH)-1:0] mem_raddr,
  input  wire logic [31:0]              mem_rdata,
  output logic                          res_valid,
  output result_item_t                  res
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  state_e          state, state_next;
  logic [AW-1:0]   head;
  logic [CW-1:0]   count;
  logic [2:0]      cmd_r;
  logic [31:0]     val_r;
  logic [CW-1:0]   idx;
  logic            cmp_vld;
  logic [AW-1:0]   last_raddr;
  logic [AW-1:0]   hole;
  logic            wr_pend;
  logic [AW-1:0]   wr_addr;
  status_e         status_r;
  logic            found_r;
  logic [31:0]     front_r;

  logic [AW-1:0]   offset;
  logic [AW-1:0]   slot;
  logic [CW-1:0]   count_m1;
  logic            full;
  logic            empty;
  logic            is_push;
  logic            is_pop;
  logic            is_search;
  logic            match;
  logic            scan_more;

  bdq_slot #(.DEPTH(DEPTH)) u_slot (
    .head   (head),
    .offset (offset),
    .slot   (slot)
  );

  assign count_m1  = count - CW'(1);
  assign full      = (count == CW'(DEPTH));
  assign empty     = (count == '0);
  assign is_push   = (cmd_r == CMD_PUSH_FRONT) || (cmd_r == CMD_PUSH_BACK);
  assign is_pop    = (cmd_r == CMD_POP_FRONT) || (cmd_r == CMD_POP_BACK);
  assign is_search = (cmd_r == CMD_CONTAINS) || (cmd_r == CMD_REMOVE);
  assign match     = cmp_vld && (mem_rdata == val_r);
  assign scan_more = (idx < count);
  assign busy      = (state != S_IDLE);
  assign mem_raddr = slot;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (is_search && !empty) begin
          state_next = S_SCAN;
        end else begin
          state_next = S_FETCH;
        end
      end
      S_SCAN: begin
        if (match) begin
          state_next = (cmd_r == CMD_REMOVE) ? S_SHIFT : S_FETCH;
        end else if (cmp_vld && !scan_more) begin
          state_next = S_FETCH;
        end
      end
      S_SHIFT: begin
        if (!scan_more) begin
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        state_next = empty ? S_IDLE : S_FRONT;
      end
      S_FRONT: state_next = S_BACK;
      S_BACK:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs: slot offset selection, write port and result.
  always_comb begin
    offset    = '0;
    mem_we    = 1'b0;
    mem_waddr = slot;
    mem_wdata = val_r;
    res_valid = 1'b0;
    case (state)
      S_EXEC: begin
        case (cmd_r)
          CMD_PUSH_FRONT: begin
            offset = AW'(DEPTH - 1);
            mem_we = !full;
          end
          CMD_PUSH_BACK: begin
            offset = count[AW-1:0];
            mem_we = !full;
          end
          CMD_POP_FRONT: offset = AW'(1);
          default:       offset = '0;
        endcase
      end
      S_SCAN:  offset = idx[AW-1:0];
      S_SHIFT: begin
        offset    = idx[AW-1:0];
        mem_we    = wr_pend;
        mem_waddr = wr_addr;
        mem_wdata = mem_rdata;
      end
      S_FETCH: begin
        offset    = '0;
        res_valid = empty;
      end
      S_FRONT: offset = count_m1[AW-1:0];
      S_BACK:  res_valid = 1'b1;
      default: offset = '0;
    endcase
  end

  always_comb begin
    res.status      = status_r;
    res.found       = found_r;
    res.count       = COUNT_W'(count);
    res.front_value = (state == S_BACK) ? front_r : '0;
    res.back_value  = (state == S_BACK) ? mem_rdata : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      head     <= '0;
      count    <= '0;
      cmp_vld  <= 1'b0;
      wr_pend  <= 1'b0;
      status_r <= ST_OK;
      found_r  <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (start) begin
            cmd_r    <= command.cmd;
            val_r    <= command.value;
            status_r <= ST_OK;
            found_r  <= 1'b0;
          end
        end
        S_EXEC: begin
          idx     <= '0;
          cmp_vld <= 1'b0;
          wr_pend <= 1'b0;
          if (is_push) begin
            if (full) begin
              status_r <= ST_FULL;
            end else begin
              count <= count + CW'(1);
              if (cmd_r == CMD_PUSH_FRONT) begin
                head <= slot;
              end
            end
          end else if (is_pop) begin
            if (empty) begin
              status_r <= ST_EMPTY;
            end else begin
              count <= count_m1;
              if (cmd_r == CMD_POP_FRONT) begin
                head <= slot;
              end
            end
          end else if (is_search && empty) begin
            status_r <= ST_EMPTY;
          end
        end
        S_SCAN: begin
          if (match) begin
            // idx already points one past the matching entry.
            found_r <= 1'b1;
            hole    <= last_raddr;
          end else begin
            if (cmp_vld && !scan_more) begin
              status_r <= ST_NOT_FOUND;
            end
            if (scan_more) begin
              idx <= idx + CW'(1);
            end
            cmp_vld    <= scan_more;
            last_raddr <= slot;
          end
        end
        S_SHIFT: begin
          if (scan_more) begin
            wr_pend <= 1'b1;
            wr_addr <= hole;
            hole    <= slot;
            idx     <= idx + CW'(1);
          end else begin
            wr_pend <= 1'b0;
            count   <= count_m1;
          end
        end
        S_FRONT: front_r <= mem_rdata;
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/bounded_deque_bag_tb.sv =====
`timescale 1ns / 1ps

module bounded_deque_bag_tb;
  import bdq_pkg::*;

  // The block is instantiated at its default size; the reference deque below
  // uses the same depth so the two wrap around at the same slot.
  localparam int unsigned DEPTH = DEPTH_DEF;

  // Command codes the package leaves unnamed. The block must treat them as
  // no-ops that still return one result item.
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;

  localparam logic signed [31:0] VAL_MIN = 32'h8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'h7fff_ffff;
  localparam logic signed [31:0] CORNER_VALUES [4] = '{VAL_MIN, VAL_MAX, 32'sd0, -32'sd1};

  localparam int unsigned N_DIRECTED   = 25;
  localparam int unsigned RANDOM_ITEMS = 1700;
  // The final stretch of random items is sent back to back with no gaps.
  localparam int unsigned TAIL_ITEMS   = 200;
  // Both bounds at the end leave a wide margin over one worst-case item, a
  // search or remove on a full deque.
  localparam int unsigned DRAIN_LIMIT  = 2000;
  localparam int unsigned SETTLE_TIME  = 3 * DEPTH;

  // The random part moves through traffic mixes. Each mix is a weight per
  // command code, indexed by the code itself (0 to 7).
  typedef enum int unsigned {
    MIX_FILL,
    MIX_DRAIN,
    MIX_BALANCED,
    MIX_SEARCH
  } traffic_mix_e;

  localparam int unsigned CMD_WEIGHTS [4][8] = '{
    '{30, 30,  6,  6, 12, 12, 2, 2},
    '{ 6,  6, 30, 30, 12, 12, 2, 2},
    '{16, 16, 14, 14, 16, 16, 4, 4},
    '{10, 10,  5,  5, 30, 30, 5, 5}
  };

  // One row of the directed sequence. When has_literal is set, the expected
  // result is the literal in the row; otherwise the reference deque decides.
  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] value;
    logic               has_literal;
    result_item_t       literal;
  } directed_row_t;

  logic         clk;
  logic         rst;
  logic         start;
  logic         busy;
  cmd_item_t    command;
  logic         done;
  result_item_t result;

  bounded_deque_bag dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .command (command),
    .done    (done),
    .result  (result)
  );

  // Reference deque: a circular store addressed from the front slot, the same
  // organization the block is expected to keep.
  logic signed [31:0] deque_store [DEPTH];
  int unsigned        deque_head;
  int unsigned        deque_count;

  // Results predicted at acceptance, oldest first.
  result_item_t pending_results [$];
  result_item_t oldest_result;
  int unsigned  results_seen;
  int unsigned  error_count;

  directed_row_t directed_rows [N_DIRECTED];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs or stops answering.
  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

  // Prints the first few mismatches and counts all of them.
  task automatic report_mismatch(string msg);
    error_count++;
    if (error_count <= 40) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                results_seen, name, got, want));
    end
  endtask

  function automatic result_item_t outcome(status_e status, logic found, int unsigned count,
                                           logic signed [31:0] front_value,
                                           logic signed [31:0] back_value);
    result_item_t r;
    r.status      = status;
    r.found       = found;
    r.count       = COUNT_W'(count);
    r.front_value = front_value;
    r.back_value  = back_value;
    return r;
  endfunction

  function automatic int unsigned slot_at(int unsigned offset);
    return (deque_head + offset) % DEPTH;
  endfunction

  // Applies one command to the reference deque and returns the result item the
  // block must produce for it.
  function automatic result_item_t apply_command(cmd_item_t item);
    status_e     status;
    logic        found;
    int unsigned pos;
    result_item_t r;
    status = ST_OK;
    found  = 1'b0;
    pos    = 0;
    case (item.cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (deque_count >= DEPTH) begin
          status = ST_FULL;
        end else if (item.cmd == CMD_PUSH_FRONT) begin
          deque_head = (deque_head + DEPTH - 1) % DEPTH;
          deque_store[deque_head] = item.value;
          deque_count++;
        end else begin
          deque_store[slot_at(deque_count)] = item.value;
          deque_count++;
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (deque_count == 0) begin
          status = ST_EMPTY;
        end else begin
          // A pop from the front moves the front slot on, also for the last entry.
          if (item.cmd == CMD_POP_FRONT) deque_head = slot_at(1);
          deque_count--;
        end
      end
      CMD_CONTAINS, CMD_REMOVE: begin
        if (deque_count == 0) begin
          status = ST_EMPTY;
        end else begin
          // The first match counted from the front is the one that matters.
          while (pos < deque_count && deque_store[slot_at(pos)] != item.value) pos++;
          if (pos == deque_count) begin
            status = ST_NOT_FOUND;
          end else begin
            found = 1'b1;
            if (item.cmd == CMD_REMOVE) begin
              // Everything behind the match moves one slot toward the front.
              for (int unsigned i = pos; i + 1 < deque_count; i++) begin
                deque_store[slot_at(i)] = deque_store[slot_at(i + 1)];
              end
              deque_count--;
            end
          end
        end
      end
      default: ;
    endcase
    if (deque_count == 0) begin
      r = outcome(status, found, 0, 32'sd0, 32'sd0);
    end else begin
      r = outcome(status, found, deque_count, deque_store[slot_at(0)],
                  deque_store[slot_at(deque_count - 1)]);
    end
    return r;
  endfunction

  function automatic logic [2:0] pick_cmd(traffic_mix_e mix);
    int unsigned total;
    int unsigned pick;
    total = 0;
    for (int unsigned k = 0; k < 8; k++) total += CMD_WEIGHTS[mix][k];
    pick = $urandom_range(total - 1, 0);
    for (int unsigned k = 0; k < 8; k++) begin
      if (pick < CMD_WEIGHTS[mix][k]) return 3'(k);
      pick -= CMD_WEIGHTS[mix][k];
    end
    return CMD_CONTAINS;
  endfunction

  // Values are drawn so that searches hit often: many come from entries that
  // are currently held, some from a narrow band that breeds duplicates, and
  // the rest are corners or fully random words.
  function automatic logic signed [31:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(9, 0);
    if (sel < 4 && deque_count != 0) begin
      return deque_store[slot_at($urandom_range(deque_count - 1, 0))];
    end
    if (sel < 6) return 32'($urandom_range(15, 0)) - 32'sd8;
    if (sel == 6) return CORNER_VALUES[$urandom_range(3, 0)];
    return $urandom;
  endfunction

  // Called at a falling edge. Holds the item on the bus until the block takes
  // it, records the expected result, and returns at the next falling edge with
  // start still high so that a following item can go out without a gap.
  task automatic issue_command(cmd_item_t item, logic has_literal, result_item_t literal);
    result_item_t predicted;
    start   <= 1'b1;
    command <= item;
    do @(posedge clk); while (busy !== 1'b0);
    predicted = apply_command(item);
    pending_results.push_back(has_literal ? literal : predicted);
    @(negedge clk);
  endtask

  // Drops start for a burst of cycles with junk on the command bus. Half of
  // the bursts begin only once the block has gone idle, so gaps land both
  // while a command is in flight and while the block is waiting.
  task automatic idle_burst();
    cmd_item_t junk;
    junk.cmd   = 3'($urandom_range(7, 0));
    junk.value = $urandom;
    start   <= 1'b0;
    command <= junk;
    if ($urandom_range(1, 0) == 1) begin
      do @(posedge clk); while (busy !== 1'b0);
      @(negedge clk);
    end
    repeat ($urandom_range(13, 1)) @(negedge clk);
  endtask

  // Holds off the next item until every outstanding result has come back.
  task automatic wait_for_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Result checker. The block cannot be held off, so every cycle with done
  // high carries a result item that must match the oldest prediction.
  always @(posedge clk) begin
    if (!rst) begin
      if (done === 1'b1) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing pending", results_seen));
        end else begin
          oldest_result = pending_results.pop_front();
          check_field("status", 32'(result.status), 32'(oldest_result.status));
          check_field("found", 32'(result.found), 32'(oldest_result.found));
          check_field("count", 32'(result.count), 32'(oldest_result.count));
          check_field("front_value", result.front_value, oldest_result.front_value);
          check_field("back_value", result.back_value, oldest_result.back_value);
        end
        results_seen++;
      end else if (done !== 1'b0) begin
        report_mismatch("done strobe is unknown");
      end
    end
  end

  initial begin
    cmd_item_t    item;
    traffic_mix_e mix;
    int unsigned  sent;
    int unsigned  mix_length;
    int unsigned  waited;
    logic         gaps_on;

    error_count  = 0;
    results_seen = 0;
    deque_head   = 0;
    deque_count  = 0;
    for (int unsigned i = 0; i < DEPTH; i++) deque_store[i] = '0;

    // Directed sequence. The opening rows hit pops, searches and a spare code
    // on an empty deque; then two entries at the value extremes (the push at
    // the front wraps the front slot below zero), hits and misses, both spare
    // codes, duplicates of zero so a remove must take the first one, removes
    // at the front, middle and back, pops down to empty, and a push after that.
    directed_rows = '{
      '{CMD_POP_FRONT,  32'sh1234,   1'b1, outcome(ST_EMPTY, 1'b0, 0, 32'sd0, 32'sd0)},
      '{CMD_POP_BACK,   -32'sd1,     1'b1, outcome(ST_EMPTY, 1'b0, 0, 32'sd0, 32'sd0)},
      '{CMD_CONTAINS,   32'sd0,      1'b1, outcome(ST_EMPTY, 1'b0, 0, 32'sd0, 32'sd0)},
      '{CMD_REMOVE,     VAL_MIN,     1'b1, outcome(ST_EMPTY, 1'b0, 0, 32'sd0, 32'sd0)},
      '{CMD_SPARE_6,    VAL_MAX,     1'b1, outcome(ST_OK, 1'b0, 0, 32'sd0, 32'sd0)},
      '{CMD_PUSH_BACK,  VAL_MAX,     1'b1, outcome(ST_OK, 1'b0, 1, VAL_MAX, VAL_MAX)},
      '{CMD_PUSH_FRONT, VAL_MIN,     1'b1, outcome(ST_OK, 1'b0, 2, VAL_MIN, VAL_MAX)},
      '{CMD_CONTAINS,   VAL_MIN,     1'b1, outcome(ST_OK, 1'b1, 2, VAL_MIN, VAL_MAX)},
      '{CMD_CONTAINS,   32'sd0,      1'b1, outcome(ST_NOT_FOUND, 1'b0, 2, VAL_MIN, VAL_MAX)},
      '{CMD_REMOVE,     32'sd5,      1'b1, outcome(ST_NOT_FOUND, 1'b0, 2, VAL_MIN, VAL_MAX)},
      '{CMD_SPARE_7,    -32'sd1,     1'b1, outcome(ST_OK, 1'b0, 2, VAL_MIN, VAL_MAX)},
      '{CMD_PUSH_BACK,  -32'sd1,     1'b0, '0},
      '{CMD_PUSH_BACK,  32'sd0,      1'b0, '0},
      '{CMD_PUSH_FRONT, 32'sd0,      1'b0, '0},
      '{CMD_PUSH_BACK,  32'h5555_5555, 1'b0, '0},
      '{CMD_PUSH_FRONT, 32'haaaa_aaaa, 1'b0, '0},
      '{CMD_REMOVE,     32'sd0,      1'b0, '0},
      '{CMD_CONTAINS,   32'sd0,      1'b0, '0},
      '{CMD_REMOVE,     VAL_MAX,     1'b0, '0},
      '{CMD_REMOVE,     32'h5555_5555, 1'b0, '0},
      '{CMD_REMOVE,     32'haaaa_aaaa, 1'b0, '0},
      '{CMD_POP_FRONT,  32'sd7,      1'b0, '0},
      '{CMD_POP_BACK,   VAL_MIN,     1'b0, '0},
      '{CMD_POP_BACK,   VAL_MAX,     1'b0, '0},
      '{CMD_PUSH_FRONT, 32'sd1,      1'b0, '0}
    };

    // Every input is known from time zero; reset is applied, then released at a falling edge.
    rst     = 1'b1;
    start   = 1'b0;
    command = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      item.cmd   = directed_rows[i].cmd;
      item.value = directed_rows[i].value;
      issue_command(item, directed_rows[i].has_literal, directed_rows[i].literal);
    end

    // Let the directed part finish completely before the random traffic.
    wait_for_results();

    // Random part. The first mix fills the deque well past full so pushes get
    // dropped, the second drains it past empty, and the rest are chosen at
    // random. Some mixes run with sender gaps and some without, and some
    // start only after every outstanding result has come back.
    sent = 0;
    mix  = MIX_FILL;
    while (sent < RANDOM_ITEMS) begin
      mix_length = (mix == MIX_FILL || mix == MIX_DRAIN) ? 250 : $urandom_range(200, 60);
      gaps_on    = ($urandom_range(2, 0) != 0);
      if (sent != 0 && sent + TAIL_ITEMS < RANDOM_ITEMS &&
          $urandom_range(2, 0) == 0) begin
        wait_for_results();
      end
      for (int unsigned k = 0; k < mix_length && sent < RANDOM_ITEMS; k++) begin
        item.cmd   = pick_cmd(mix);
        item.value = pick_value();
        issue_command(item, 1'b0, '0);
        sent++;
        if (gaps_on && sent + TAIL_ITEMS < RANDOM_ITEMS && $urandom_range(3, 0) == 0) begin
          idle_burst();
        end
      end
      if (mix == MIX_FILL && sent <= mix_length) begin
        mix = MIX_DRAIN;
      end else begin
        mix = traffic_mix_e'($urandom_range(3, 0));
      end
    end
    start <= 1'b0;

    // Wait for the last results, bounded, then watch a while longer for any
    // stray strobe before judging the run.
    waited = 0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_TIME) @(posedge clk);
    if (pending_results.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived", pending_results.size()));
    end

    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
